FILE: src/string_escape_decoder_defines.svh
// assertion macros shared by the escape decoder modules
`ifndef STRING_ESCAPE_DECODER_DEFINES_SVH
`define STRING_ESCAPE_DECODER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define SED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sed assertion failed");
// condition must never be seen outside reset
`define SED_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sed forbidden condition seen");
`else
`define SED_ASSERT(lbl, clk, rst_n, prop)
`define SED_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: src/sed_pkg.sv
// types, constants and helper functions of the escape decoder
`default_nettype none

package sed_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_OUT     = 4;
    localparam int SLOT_W      = $clog2(MAX_OUT);
    localparam int CNT_W       = $clog2(MAX_OUT + 1);
    localparam int QUEUE_DEPTH = 4;

    // characters that steer decoding
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h61;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_V      = 8'h76;
    localparam logic [BYTE_W-1:0] CH_X      = 8'h78;

    // control codes produced by the named escapes
    localparam logic [BYTE_W-1:0] CODE_BEL = 8'h07;
    localparam logic [BYTE_W-1:0] CODE_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CODE_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] CODE_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_HT  = 8'h09;
    localparam logic [BYTE_W-1:0] CODE_VT  = 8'h0B;

    // octal collection limits
    localparam logic [BYTE_W-1:0] OCT_LIMIT      = 8'd32;
    localparam logic [1:0]        OCT_MAX_DIGITS = 2'd3;
    localparam logic [4:0]        OCT_PREFIX     = 5'b00110;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX1  = 3'd2,
        MODE_HEX2  = 3'd3,
        MODE_OCT   = 3'd4
    } mode_t;

    // decoded bytes of one input word, collected in order
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]               cnt;
    } sed_emit_t;

    // one queue entry: a run of one to four output words
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] data;
        logic [SLOT_W-1:0]              last_idx;
        logic                           str_end;
    } sed_entry_t;

    function automatic sed_emit_t emit_byte(sed_emit_t e, logic [BYTE_W-1:0] b);
        sed_emit_t r;
        r = e;
        if (e.cnt < CNT_W'(MAX_OUT)) begin
            r.data[e.cnt[SLOT_W-1:0]] = b;
            r.cnt = e.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic logic hex_ok(logic [BYTE_W-1:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    // digit value, valid only where hex_ok holds
    function automatic logic [3:0] hex_val(logic [BYTE_W-1:0] b);
        logic [3:0] v;
        if (b <= 8'h39) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/sed_front.sv
// front end: accepts input words, runs the escape state machine, queues output runs
`default_nettype none
`include "string_escape_decoder_defines.svh"

module sed_front (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire [7:0]               s_in_byte,
    input  wire                     s_in_last,
    input  wire                     q_full,
    output logic                    push,
    output sed_pkg::sed_entry_t     push_entry
);
    import sed_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic [BYTE_W-1:0]  oval_reg, oval_next;
    logic [1:0]         odig_reg, odig_next;
    logic [BYTE_W-1:0]  oct_sum;
    logic [1:0]         odig_inc;
    logic               accept;
    sed_emit_t          em;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            held_reg <= '0;
            oval_reg <= '0;
            odig_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            oval_reg <= oval_next;
            odig_reg <= odig_next;
        end
    end

    // decode one word and flush at string end
    always_comb begin
        em        = '0;
        mode_next = mode_reg;
        held_next = held_reg;
        oval_next = oval_reg;
        odig_next = odig_reg;
        oct_sum   = {oval_reg[4:0], s_in_byte[2:0]};
        odig_inc  = odig_reg + 2'd1;

        unique case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                unique case (s_in_byte)
                    CH_A: em = emit_byte(em, CODE_BEL);
                    CH_B: em = emit_byte(em, CODE_BS);
                    CH_F: em = emit_byte(em, CODE_FF);
                    CH_N: em = emit_byte(em, CODE_LF);
                    CH_T: em = emit_byte(em, CODE_HT);
                    CH_V: em = emit_byte(em, CODE_VT);
                    CH_SQUOTE, CH_DQUOTE, CH_BSLASH: em = emit_byte(em, s_in_byte);
                    CH_X: mode_next = MODE_HEX1;
                    default: begin
                        if (s_in_byte[7:3] == OCT_PREFIX) begin
                            oval_next = {5'b0, s_in_byte[2:0]};
                            odig_next = 2'd1;
                            mode_next = MODE_OCT;
                        end else begin
                            // unknown escape passes through
                            em = emit_byte(em, CH_BSLASH);
                            em = emit_byte(em, s_in_byte);
                        end
                    end
                endcase
            end
            MODE_HEX1: begin
                if (hex_ok(s_in_byte)) begin
                    held_next = s_in_byte;
                    mode_next = MODE_HEX2;
                end else begin
                    em        = emit_byte(em, CH_BSLASH);
                    em        = emit_byte(em, CH_X);
                    mode_next = MODE_PLAIN;
                    if (s_in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        em = emit_byte(em, s_in_byte);
                    end
                end
            end
            MODE_HEX2: begin
                mode_next = MODE_PLAIN;
                if (hex_ok(held_reg) && hex_ok(s_in_byte)) begin
                    em = emit_byte(em, {hex_val(held_reg), hex_val(s_in_byte)});
                end else begin
                    // bad hex: replay held digit and this byte as text
                    em = emit_byte(em, CH_BSLASH);
                    em = emit_byte(em, CH_X);
                    if (held_reg == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        em = emit_byte(em, held_reg);
                    end
                    if (s_in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        em = emit_byte(em, s_in_byte);
                    end
                end
            end
            MODE_OCT: begin
                if (s_in_byte[7:3] == OCT_PREFIX) begin
                    oval_next = oct_sum;
                    odig_next = odig_inc;
                    if (odig_inc == OCT_MAX_DIGITS || oct_sum >= OCT_LIMIT ||
                        odig_inc == 2'd0) begin
                        em        = emit_byte(em, oct_sum);
                        mode_next = MODE_PLAIN;
                    end
                end else begin
                    em        = emit_byte(em, oval_reg);
                    mode_next = MODE_PLAIN;
                    if (s_in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        em = emit_byte(em, s_in_byte);
                    end
                end
            end
            default: begin
                mode_next = MODE_PLAIN;
                if (s_in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    em = emit_byte(em, s_in_byte);
                end
            end
        endcase

        // flush whatever escape is pending at string end
        if (s_in_last) begin
            unique case (mode_next)
                MODE_ESC: em = emit_byte(em, CH_BSLASH);
                MODE_HEX1: begin
                    em = emit_byte(em, CH_BSLASH);
                    em = emit_byte(em, CH_X);
                end
                MODE_HEX2: begin
                    em = emit_byte(em, CH_BSLASH);
                    em = emit_byte(em, CH_X);
                    em = emit_byte(em, held_next);
                end
                MODE_OCT: em = emit_byte(em, oval_next);
                default: ;
            endcase
            mode_next = MODE_PLAIN;
        end
    end

    // queue entry for a non-empty run
    always_comb begin
        push                = accept && (em.cnt != '0);
        push_entry.data     = em.data;
        push_entry.last_idx = SLOT_W'(em.cnt - CNT_W'(1));
        push_entry.str_end  = s_in_last;
    end

    `SED_ASSERT(a_last_ends_plain, aclk, aresetn, accept && s_in_last |=> mode_reg == MODE_PLAIN)

endmodule

`default_nettype wire

FILE: src/sed_queue.sv
// small queue of decoded runs between front and back
`default_nettype none
`include "string_escape_decoder_defines.svh"

module sed_queue #(
    parameter int DEPTH = sed_pkg::QUEUE_DEPTH
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  sed_pkg::sed_entry_t     push_entry,
    input  wire                     pop,
    output sed_pkg::sed_entry_t     head,
    output logic                    full,
    output logic                    empty
);
    import sed_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    sed_entry_t          mem [DEPTH];
    logic [ADDR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W_Q-1:0]  count_reg;

    assign full  = (count_reg == CNT_W_Q'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + ADDR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + ADDR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W_Q'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W_Q'(1);
            end
        end
    end

    `SED_NEVER(a_q_overflow, aclk, aresetn, push && full)
    `SED_NEVER(a_q_underflow, aclk, aresetn, pop && empty)

endmodule

`default_nettype wire

FILE: src/sed_back.sv
// back end: walks the head run one word per cycle, while m_ready allows, into the output register
`default_nettype none
`include "string_escape_decoder_defines.svh"

module sed_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  sed_pkg::sed_entry_t     head,
    input  wire                     q_empty,
    output logic                    pop,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_run_last,
    output logic                    m_string_end
);
    import sed_pkg::*;

    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg;
    logic               m_run_last_reg;
    logic               m_string_end_reg;
    logic               load;
    logic               at_end;

    // next word selection
    always_comb begin
        load         = !q_empty && (!m_valid_reg || m_ready);
        at_end       = (idx_reg == head.last_idx);
        pop          = load && at_end;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = at_end ? '0 : idx_reg + SLOT_W'(1);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_reg       <= head.data[idx_reg];
            m_run_last_reg   <= at_end;
            m_string_end_reg <= at_end && head.str_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_string_end = m_string_end_reg;

    `SED_ASSERT(a_idx_in_run, aclk, aresetn, !q_empty |-> idx_reg <= head.last_idx)
    `SED_NEVER(a_end_mid_run, aclk, aresetn, m_valid_reg && m_string_end_reg && !m_run_last_reg)

endmodule

`default_nettype wire

FILE: src/string_escape_decoder.sv
// top level of the backslash escape decoder
//
//  port group   dir   handshake          payload
//  s_           in    s_valid/s_ready    s_in_byte[7:0], s_in_last
//  m_           out   m_valid/m_ready    m_out_byte[7:0], m_run_last, m_string_end
//
// one input word is taken per cycle while the run queue has room
// each input word yields zero to four output words, sent one per cycle while m_ready is high
// output words pass through the run queue, then the back end's output register
// output rate of one word per cycle while m_ready is high is set by the back end walking the head run
// reset clears the decode mode, the queue pointers and the output valid
// a stall on m_ fills the queue of QUEUE_DEPTH runs, then s_ready drops
`default_nettype none

module string_escape_decoder #(
    parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [7:0]  s_in_byte,
    input  wire        s_in_last,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_string_end
);
    import sed_pkg::*;

    sed_entry_t push_entry;
    sed_entry_t head;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    // decode and classify
    sed_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // run queue
    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // serialize runs to the output
    sed_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_string_end (m_string_end)
    );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for the backslash escape decoder
`timescale 1ns / 100ps

module tb;
    import sed_pkg::*;

    // character codes used by the decoder model and the string builder
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_Q  = 8'h71;
    localparam logic [7:0] CH_Z  = 8'h7A;

    localparam int RAND_BYTES = 128;
    localparam int LONG_HOLD  = 60;
    localparam int HOLD_AFTER = 80;
    localparam int TAIL_WAIT  = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } str_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } dec_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;
    logic       m_string_end;

    string_escape_decoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_string_end(m_string_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // string bytes waiting to be sent, decoded words waiting to be seen
    str_byte_t  tx_bytes[$];
    dec_word_t  decoded_q[$];
    int         total_bytes = 0;
    int         total_strings = 0;
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_errors = 0;
    int         pending_words = 0;

    // decoder model state
    mode_t      dec_mode = MODE_PLAIN;
    logic [7:0] hex_hold = 8'h00;
    logic [7:0] oct_val = 8'h00;
    logic [1:0] oct_cnt = 2'd0;
    logic [7:0] word_buf [4];
    int         word_cnt;

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_F) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [7:0] nibble(input logic [7:0] c);
        if (c <= CH_9) begin
            return c - CH_0;
        end else if (c >= CH_A) begin
            return c - CH_A + 8'd10;
        end
        return c - CH_UA + 8'd10;
    endfunction

    function automatic bit is_oct(input logic [7:0] c);
        return c >= CH_0 && c <= CH_7;
    endfunction

    // at most four words per input; anything further is dropped
    task automatic put_word(input logic [7:0] b);
        if (word_cnt < 4) begin
            word_buf[word_cnt] = b;
            word_cnt++;
        end
    endtask

    task automatic plain_in(input logic [7:0] b);
        if (b == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            put_word(b);
        end
    endtask

    task automatic escape_in(input logic [7:0] b);
        dec_mode = MODE_PLAIN;
        case (b)
            CH_A:      put_word(CODE_BEL);
            CH_B:      put_word(CODE_BS);
            CH_F:      put_word(CODE_FF);
            CH_N:      put_word(CODE_LF);
            CH_T:      put_word(CODE_HT);
            CH_V:      put_word(CODE_VT);
            CH_SQUOTE: put_word(CH_SQUOTE);
            CH_DQUOTE: put_word(CH_DQUOTE);
            CH_BSLASH: put_word(CH_BSLASH);
            CH_X:      dec_mode = MODE_HEX1;
            default: begin
                if (is_oct(b)) begin
                    oct_val = b - CH_0;
                    oct_cnt = 2'd1;
                    dec_mode = MODE_OCT;
                end else begin
                    put_word(CH_BSLASH);
                    put_word(b);
                end
            end
        endcase
    endtask

    // decode one string byte and queue the words it yields
    task automatic decode_input(input logic [7:0] b, input logic last);
        logic [7:0] v;
        word_cnt = 0;
        case (dec_mode)
            MODE_ESC: escape_in(b);
            MODE_HEX1: begin
                if (is_hex(b)) begin
                    hex_hold = b;
                    dec_mode = MODE_HEX2;
                end else begin
                    put_word(CH_BSLASH);
                    put_word(CH_X);
                    dec_mode = MODE_PLAIN;
                    plain_in(b);
                end
            end
            MODE_HEX2: begin
                dec_mode = MODE_PLAIN;
                if (is_hex(hex_hold) && is_hex(b)) begin
                    put_word((nibble(hex_hold) << 4) | nibble(b));
                end else begin
                    put_word(CH_BSLASH);
                    put_word(CH_X);
                    plain_in(hex_hold);
                    plain_in(b);
                end
            end
            MODE_OCT: begin
                if (is_oct(b)) begin
                    v = {oct_val[4:0], 3'b000} + (b - CH_0);
                    oct_val = v;
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt >= 2'd3 || v >= OCT_LIMIT || oct_cnt == 2'd0) begin
                        put_word(oct_val);
                        dec_mode = MODE_PLAIN;
                    end
                end else begin
                    put_word(oct_val);
                    dec_mode = MODE_PLAIN;
                    plain_in(b);
                end
            end
            default: begin
                dec_mode = MODE_PLAIN;
                plain_in(b);
            end
        endcase
        // string end flushes a pending escape
        if (last) begin
            case (dec_mode)
                MODE_ESC: put_word(CH_BSLASH);
                MODE_HEX1: begin
                    put_word(CH_BSLASH);
                    put_word(CH_X);
                end
                MODE_HEX2: begin
                    put_word(CH_BSLASH);
                    put_word(CH_X);
                    put_word(hex_hold);
                end
                MODE_OCT: put_word(oct_val);
                default: ;
            endcase
            dec_mode = MODE_PLAIN;
        end
        for (int k = 0; k < word_cnt; k++) begin
            decoded_q.push_back('{word_buf[k], k == word_cnt - 1,
                                  (k == word_cnt - 1) && last});
        end
    endtask

    // string building
    logic [7:0] str_buf[$];

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) begin
            return CH_0 + v;
        end
        return ($urandom_range(0, 1) != 0) ? CH_UA + v - 8'd10 : CH_A + v - 8'd10;
    endfunction

    function automatic logic [7:0] rand_named_char();
        case ($urandom_range(0, 8))
            0: return CH_A;
            1: return CH_B;
            2: return CH_F;
            3: return CH_N;
            4: return CH_T;
            5: return CH_V;
            6: return CH_SQUOTE;
            7: return CH_DQUOTE;
            default: return CH_BSLASH;
        endcase
    endfunction

    // push the built string as bytes, in_last on its final byte
    task automatic send_string(input bit drain_first);
        for (int i = 0; i < str_buf.size(); i++) begin
            tx_bytes.push_back('{str_buf[i], i == str_buf.size() - 1,
                                 drain_first && i == 0});
        end
        total_bytes += str_buf.size();
        total_strings++;
        str_buf.delete();
    endtask

    // one random token: plain byte, escape, or a broken escape
    task automatic add_token();
        int kind;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            str_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 50) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(rand_named_char());
        end else if (kind < 62) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(CH_X);
            str_buf.push_back(rand_hex_char());
            str_buf.push_back(rand_hex_char());
        end else if (kind < 73) begin
            str_buf.push_back(CH_BSLASH);
            repeat ($urandom_range(1, 4)) str_buf.push_back(CH_0 + 8'($urandom_range(0, 7)));
        end else if (kind < 81) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(CH_X);
            if ($urandom_range(0, 1) != 0) str_buf.push_back(rand_hex_char());
            c = 8'($urandom_range(0, 255));
            str_buf.push_back(is_hex(c) ? CH_Z : c);
        end else if (kind < 93) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            // truncated escape, flushed if it ends the string
            str_buf.push_back(CH_BSLASH);
            if ($urandom_range(0, 2) != 0) str_buf.push_back(CH_X);
            if ($urandom_range(0, 1) != 0) str_buf.push_back(rand_hex_char());
        end
    endtask

    task automatic add_directed(input logic [7:0] b);
        str_buf.push_back(b);
    endtask

    // driver: gaps mostly short, some long, with stretches of none
    int tx_gap = 0;
    int tx_calm = 0;
    bit tx_drain = 1'b0;
    str_byte_t tx_cur;

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(15, 40);
            return 0;
        end else if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 20);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) n_sent++;
            if (s_valid && !s_ready) begin
                // word held until taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (tx_bytes.size() == 0) begin
                s_valid <= 1'b0;
            end else if (tx_bytes[0].drain && !tx_drain) begin
                tx_drain = 1'b1;
                s_valid <= 1'b0;
            end else if (tx_drain && pending_words != 0) begin
                s_valid <= 1'b0;
            end else begin
                tx_cur = tx_bytes.pop_front();
                tx_drain = 1'b0;
                s_valid <= 1'b1;
                s_in_byte <= tx_cur.data;
                s_in_last <= tx_cur.last;
                tx_gap = pick_gap(tx_calm);
            end
        end
    end

    // receiver: random stalls plus one long hold-off to fill the block
    int rx_stall = 0;
    int rx_calm = 0;
    int rx_taken = 0;
    bit rx_held = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) rx_taken++;
            if (!rx_held && rx_taken >= HOLD_AFTER) begin
                rx_held = 1'b1;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    // monitor: model each taken byte, check each taken word
    dec_word_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) decode_input(s_in_byte, s_in_last);
            if (m_valid && m_ready) begin
                n_checked++;
                if (decoded_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("unexpected word: out_byte %h run_last %b string_end %b",
                                 m_out_byte, m_run_last, m_string_end);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.data || m_run_last !== want.run_last ||
                        m_string_end !== want.str_end) begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                            $display({"word %0d mismatch: out_byte %h/%h run_last %b/%b ",
                                      "string_end %b/%b (expected/actual)"},
                                     n_checked, want.data, m_out_byte, want.run_last,
                                     m_run_last, want.str_end, m_string_end);
                    end
                end
            end
            pending_words <= decoded_q.size();
        end
    end

    // watchdog on cycles with no word moving
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d words outstanding", decoded_q.size());
            $display("[string_escape_decoder] ERROR");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        // named escape, unknown escape with top byte
        add_directed(CH_BSLASH); add_directed(CH_N);
        add_directed(CH_BSLASH); add_directed(8'hFF);
        // mixed case hex giving top value, then bad hex with zero byte
        add_directed(CH_BSLASH); add_directed(CH_X); add_directed(CH_F); add_directed(CH_UF);
        add_directed(CH_BSLASH); add_directed(CH_X); add_directed(8'h00);
        send_string(1'b0);
        // octal stops once value reaches 32, then three digit octal
        add_directed(CH_BSLASH); add_directed(CH_0 + 8'd4);
        add_directed(CH_0);      add_directed(CH_0);
        add_directed(CH_BSLASH); add_directed(CH_0 + 8'd3);
        add_directed(CH_7);      add_directed(CH_7);
        send_string(1'b0);
        // octal ended by backslash, bad second hex digit, lone backslash flushed
        add_directed(CH_BSLASH); add_directed(CH_7); add_directed(CH_BSLASH);
        add_directed(CH_X);      add_directed(CH_UA); add_directed(CH_BSLASH);
        send_string(1'b0);
        // truncated hex and octal at string end
        add_directed(CH_BSLASH); add_directed(CH_X);
        send_string(1'b0);
        add_directed(CH_BSLASH); add_directed(CH_0 + 8'd5);
        send_string(1'b0);
        // random strings; the first waits for the block to drain
        while (total_bytes < 29 + RAND_BYTES) begin
            repeat ($urandom_range(1, 5)) add_token();
            if ($urandom_range(0, 9) == 0) add_directed(CH_Q + 8'($urandom_range(0, 3)));
            send_string(total_strings == 5);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_sent < total_bytes || decoded_q.size() != 0) @(negedge aclk);
        repeat (TAIL_WAIT) @(negedge aclk);

        $display("sent %0d bytes in %0d strings, checked %0d decoded words",
                 total_bytes, total_strings, n_checked);
        $display("covered named, hex, octal, bad and truncated escapes under stalls");
        if (n_errors == 0 && decoded_q.size() == 0) begin
            $display("[string_escape_decoder] OK");
        end else begin
            $display("%0d errors, %0d words missing", n_errors, decoded_q.size());
            $display("[string_escape_decoder] ERROR");
        end
        $finish;
    end

endmodule
